### rtl/core/hrl_pkg.sv
// hrl_pkg: shared types, constants and the hex digit decoder for the
// hex record loader. Depends on nothing; every other file uses it.
`timescale 1ns / 1ps

package hrl_pkg;

    localparam int unsigned ADDR_W        = 16;
    localparam int unsigned DATA_W        = 8;
    localparam int unsigned CHAR_W        = 8;
    localparam int unsigned NIB_W         = 4;
    localparam int unsigned HDR_CNT_W     = 4;
    // Two digits each of count, type and four of address
    localparam logic [HDR_CNT_W-1:0] HEADER_DIGITS = 4'd8;

    localparam logic [CHAR_W-1:0] CHAR_COLON   = 8'h3A;
    localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE    = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_F = 8'h46;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_F = 8'h66;
    localparam logic [CHAR_W-1:0] HEX_TEN      = 8'd10;
    localparam logic [DATA_W-1:0] BYTE_ALL_ONES = 8'hFF;

    // Record type that carries data
    localparam logic [DATA_W-1:0] REC_DATA = 8'h00;

    // Which header byte a completed digit pair belongs to
    typedef enum logic [1:0] {
        HDR_COUNT   = 2'd0,
        HDR_ADDR_HI = 2'd1,
        HDR_ADDR_LO = 2'd2,
        HDR_TYPE    = 2'd3
    } hdr_field_e;

    // Decoded digit: bad flag set when the character is no hex digit
    typedef struct packed {
        logic             bad;
        logic [NIB_W-1:0] value;
    } digit_t;

    // One memory write produced by the parser
    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] address;
        logic [DATA_W-1:0] data;
    } write_t;

    // Parser status seen by the top level
    typedef struct packed {
        logic record_active;
        logic header_done;
        logic pending;
    } parse_status_t;

    function automatic digit_t hex_decode(input logic [CHAR_W-1:0] ch);
        digit_t     d;
        logic [CHAR_W-1:0] v;
        v       = '0;
        d.bad   = 1'b0;
        if (ch >= CHAR_ZERO && ch <= CHAR_NINE)
        begin
            v = ch - CHAR_ZERO;
        end
        else if (ch >= CHAR_UPPER_A && ch <= CHAR_UPPER_F)
        begin
            v = ch - CHAR_UPPER_A + HEX_TEN;
        end
        else if (ch >= CHAR_LOWER_A && ch <= CHAR_LOWER_F)
        begin
            v = ch - CHAR_LOWER_A + HEX_TEN;
        end
        else
        begin
            d.bad = 1'b1;
        end
        d.value = v[NIB_W-1:0];
        return d;
    endfunction

endpackage

### rtl/core/hrl_char_if.sv
// hrl_char_if: character channel, one text character per transaction.
// Depends on hrl_pkg for widths.
`timescale 1ns / 1ps

interface hrl_char_if;
    logic                        valid;
    logic                        ready;
    logic [hrl_pkg::CHAR_W-1:0]  char_code;
    logic                        line_start;

    modport source (output valid, output char_code, output line_start, input ready);
    modport sink   (input valid, input char_code, input line_start, output ready);
endinterface

### rtl/core/hrl_write_if.sv
// hrl_write_if: memory write channel, one address/data pair per transaction.
// Depends on hrl_pkg for widths.
`timescale 1ns / 1ps

interface hrl_write_if;
    logic                        valid;
    logic                        ready;
    logic [hrl_pkg::ADDR_W-1:0]  write_address;
    logic [hrl_pkg::DATA_W-1:0]  write_data;

    modport source (output valid, output write_address, output write_data, input ready);
    modport sink   (input valid, input write_address, input write_data, output ready);
endinterface

### rtl/core/hrl_parser.sv
// hrl_parser: record state and digit pairing, one character per cycle while take is high.
// Depends on hrl_pkg (digit decode, write and status types).
`timescale 1ns / 1ps

module hrl_parser
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          take,
    input  logic [hrl_pkg::CHAR_W-1:0]    char_code,
    input  logic                          line_start,
    output hrl_pkg::write_t               wr,
    output hrl_pkg::parse_status_t        status
);

    logic                             active_reg, active_next;
    logic [hrl_pkg::HDR_CNT_W-1:0]    seen_reg, seen_next;
    logic                             pending_reg, pending_next;
    logic [hrl_pkg::NIB_W-1:0]        first_reg, first_next;
    logic [hrl_pkg::DATA_W-1:0]       remaining_reg, remaining_next;
    logic [hrl_pkg::ADDR_W-1:0]       addr_reg, addr_next;
    logic [hrl_pkg::DATA_W-1:0]       kind_reg, kind_next;

    hrl_pkg::digit_t                  digit;
    logic [hrl_pkg::DATA_W-1:0]       low_part;
    logic [hrl_pkg::DATA_W-1:0]       full_byte;
    logic                             header_done;
    hrl_pkg::hdr_field_e              field;

    // Decode the character and form the byte a second digit would complete
    always_comb
    begin
        digit       = hrl_pkg::hex_decode(char_code);
        low_part    = digit.bad ? hrl_pkg::BYTE_ALL_ONES
                                : {{(hrl_pkg::DATA_W-hrl_pkg::NIB_W){1'b0}}, digit.value};
        full_byte   = {first_reg, {hrl_pkg::NIB_W{1'b0}}} | low_part;
        header_done = (seen_reg >= hrl_pkg::HEADER_DIGITS);
        field       = hrl_pkg::hdr_field_e'(seen_reg[2:1]);
    end

    // Next state and write for the current character
    always_comb
    begin
        active_next    = active_reg;
        seen_next      = seen_reg;
        pending_next   = pending_reg;
        first_next     = first_reg;
        remaining_next = remaining_reg;
        addr_next      = addr_reg;
        kind_next      = kind_reg;
        wr.valid       = 1'b0;
        wr.address     = addr_reg;
        wr.data        = full_byte;

        if (line_start)
        begin
            // Any line start ends the record; a colon opens a new one
            active_next  = (char_code == hrl_pkg::CHAR_COLON);
            seen_next    = '0;
            pending_next = 1'b0;
        end
        else if (active_reg)
        begin
            if (!header_done)
            begin
                seen_next = seen_reg + 1'b1;
                if (!pending_reg)
                begin
                    first_next   = digit.value | {hrl_pkg::NIB_W{digit.bad}};
                    pending_next = 1'b1;
                end
                else
                begin
                    pending_next = 1'b0;
                    unique case (field) inside
                        hrl_pkg::HDR_COUNT:   remaining_next = full_byte;
                        hrl_pkg::HDR_ADDR_HI,
                        hrl_pkg::HDR_ADDR_LO: addr_next = {addr_reg[hrl_pkg::DATA_W-1:0],
                                                           full_byte};
                        hrl_pkg::HDR_TYPE:    kind_next = full_byte;
                        default:              kind_next = kind_reg;
                    endcase
                end
            end
            else if (kind_reg == hrl_pkg::REC_DATA && remaining_reg != '0)
            begin
                if (!pending_reg)
                begin
                    first_next   = digit.value | {hrl_pkg::NIB_W{digit.bad}};
                    pending_next = 1'b1;
                end
                else
                begin
                    // Emit the byte and advance the address, wrapping at 16 bits
                    pending_next   = 1'b0;
                    wr.valid       = 1'b1;
                    addr_next      = addr_reg + 1'b1;
                    remaining_next = remaining_reg - 1'b1;
                end
            end
        end
    end

    // Hold state until a character is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            seen_reg      <= '0;
            pending_reg   <= 1'b0;
            first_reg     <= '0;
            remaining_reg <= '0;
            addr_reg      <= '0;
            kind_reg      <= '0;
        end
        else if (take)
        begin
            active_reg    <= active_next;
            seen_reg      <= seen_next;
            pending_reg   <= pending_next;
            first_reg     <= first_next;
            remaining_reg <= remaining_next;
            addr_reg      <= addr_next;
            kind_reg      <= kind_next;
        end
    end

    assign status.record_active = active_reg;
    assign status.header_done   = header_done;
    assign status.pending       = pending_reg;

endmodule

### rtl/core/hex_record_loader.sv
// hex_record_loader: top level, parses Intel HEX text into memory writes.
// Depends on hrl_pkg, hrl_char_if, hrl_write_if and hrl_parser.
//
// Usage:
//   chars  - sink of text characters; line_start marks the first character
//            of each line. A record opens when that character is a colon.
//   writes - source of memory writes, one per data byte of a type 0 record.
// Timing:
//   One character is taken per cycle while chars.ready is high. A write
//   appears on writes in the cycle after the character completing its byte;
//   the parser state and the output register are the only stages.
//   The output register holds a write while the receiver stalls; chars stays
//   ready as long as that register is empty or being emptied in the same
//   cycle, so a full-rate stream runs at one character per cycle whenever
//   writes.ready is high.
// Reset:
//   rst_n clears the record state and the output valid; characters are then
//   ignored until a line start that carries a colon.
// Checksum digits, lines without a colon and characters after the data
// produce no writes.
`timescale 1ns / 1ps

module hex_record_loader
(
    input  logic         clk,
    input  logic         rst_n,
    hrl_char_if.sink     chars,
    hrl_write_if.source  writes
);

    hrl_pkg::write_t                 wr;
    hrl_pkg::parse_status_t          status;
    logic                            take;
    logic                            out_valid_reg, out_valid_next;
    logic [hrl_pkg::ADDR_W-1:0]      out_addr_reg;
    logic [hrl_pkg::DATA_W-1:0]      out_data_reg;

    // Accept while the output register is free or draining
    assign chars.ready = !out_valid_reg || writes.ready;
    assign take        = chars.valid && chars.ready;

    hrl_parser u_parser
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .take       (take),
        .char_code  (chars.char_code),
        .line_start (chars.line_start),
        .wr         (wr),
        .status     (status)
    );

    // Load a write or drop valid once it is taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (take && wr.valid)
        begin
            out_valid_next = 1'b1;
        end
        else if (writes.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && wr.valid)
        begin
            out_addr_reg <= wr.address;
            out_data_reg <= wr.data;
        end
    end

    assign writes.valid         = out_valid_reg;
    assign writes.write_address = out_addr_reg;
    assign writes.write_data    = out_data_reg;

    // A write only comes from a second data digit of an open record
    assert property (@(posedge clk) disable iff (!rst_n)
        (take && wr.valid) |-> (status.record_active && status.header_done
                                && status.pending && !chars.line_start))
    else $error("write produced outside the data field of a record");

    // A line start never leaves a fresh write behind it
    assert property (@(posedge clk) disable iff (!rst_n)
        (take && chars.line_start && !(out_valid_reg && !writes.ready))
            |=> !writes.valid)
    else $error("write produced by a line start");

    // A completed byte never overwrites a write still waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !writes.ready) |-> !take)
    else $error("character taken while the output register is blocked");

endmodule
